FILE: rtl/core/upt_pkg.sv
package upt_pkg;

	localparam int DW = 16;
	localparam int AW = 8;
	localparam int IDXW = 3;

	localparam int DEF_SWEEP_SPAN = 60;
	localparam int DEF_DIST_FRAC_BITS = 6;

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;
	localparam logic [1:0] ST_IDLE = 2'd3;

	localparam logic [1:0] MODE_WAIT   = 2'd0;
	localparam logic [1:0] MODE_DRIVE  = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	localparam logic [IDXW-1:0] REG_WAIT_CEIL  = 3'd0;
	localparam logic [IDXW-1:0] REG_WAIT_TOL   = 3'd1;
	localparam logic [IDXW-1:0] REG_WAIT_WIN   = 3'd2;
	localparam logic [IDXW-1:0] REG_DRIVE_TOL  = 3'd3;
	localparam logic [IDXW-1:0] REG_DRIVE_LOSS = 3'd4;
	localparam logic [IDXW-1:0] REG_ARRIVE     = 3'd5;
	localparam logic [IDXW-1:0] REG_SEARCH_TOL = 3'd6;
	localparam logic [IDXW-1:0] REG_SEARCH_WIN = 3'd7;

	typedef struct packed {
		logic          kind;
		logic [1:0]    mode;
		logic [DW-1:0] echo_width_us;
		logic          echo_timeout;
	} item_t;

	typedef struct packed {
		logic [DW-1:0] distance;
		logic [1:0]    status;
		logic [AW-1:0] servo_angle;
		logic          servo_move;
		logic [AW-1:0] found_angle;
		logic [DW-1:0] pole_distance;
	} result_t;

	typedef struct packed {
		logic [DW-1:0] wait_ceiling;
		logic [DW-1:0] wait_tolerance;
		logic [5:0]    wait_window;
		logic [DW-1:0] drive_tolerance;
		logic [3:0]    drive_loss_count;
		logic [DW-1:0] arrive_distance;
		logic [DW-1:0] search_tolerance;
		logic [5:0]    search_window;
	} cfg_t;

endpackage

FILE: rtl/core/upt_if.sv
interface upt_item_if;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [1:0]            mode;
	logic [upt_pkg::DW-1:0] echo_width_us;
	logic                  echo_timeout;

	modport source (output valid, kind, mode, echo_width_us, echo_timeout, input ready);
	modport sink (input valid, kind, mode, echo_width_us, echo_timeout, output ready);
endinterface

interface upt_result_if;
	logic                   valid;
	logic                   ready;
	logic [upt_pkg::DW-1:0] distance;
	logic [1:0]             status;
	logic [upt_pkg::AW-1:0] servo_angle;
	logic                   servo_move;
	logic [upt_pkg::AW-1:0] found_angle;
	logic [upt_pkg::DW-1:0] pole_distance;

	modport source (output valid, distance, status, servo_angle, servo_move, found_angle,
		pole_distance, input ready);
	modport sink (input valid, distance, status, servo_angle, servo_move, found_angle,
		pole_distance, output ready);
endinterface

interface upt_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [upt_pkg::IDXW-1:0] index;
	logic [upt_pkg::DW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ultrasonic_pole_tracker_unit.sv
// channel  | dir | handshake     | payload
// item     | in  | valid / ready | kind, mode, echo_width_us, echo_timeout
// result   | out | valid / ready | distance, status, servo_angle, servo_move,
//          |     |               | found_angle, pole_distance
// cfg      | in  | valid / ready | index, data (ready always high)
//
// One item per cycle sustained while result ready stays high; an item passes the input
// register and then the result register. The echo conversion multiply and the run logic of
// the single-pass state update settle between the input register and the result register.
// Reset loads the register defaults and the idle tracker state; no clearing pass.
// A stalled result holds in the result register while one more item waits at the input.
module ultrasonic_pole_tracker_unit #(
	parameter int SWEEP_SPAN     = upt_pkg::DEF_SWEEP_SPAN,
	parameter int DIST_FRAC_BITS = upt_pkg::DEF_DIST_FRAC_BITS
) (
	input logic          clk,
	input logic          arst_n,
	upt_item_if.sink     item,
	upt_result_if.source result,
	upt_cfg_if.sink      cfg
);

	upt_pkg::item_t   item_s1;
	logic             valid_s1;
	upt_pkg::result_t res_s2;
	logic             valid_s2;
	upt_pkg::result_t res_next;
	upt_pkg::cfg_t    cfg_regs;
	logic [upt_pkg::DW-1:0] echo_dist;
	logic             advance;
	logic             take;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	upt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	upt_dist_conv #(
		.DIST_FRAC_BITS (DIST_FRAC_BITS)
	) u_conv (
		.echo_width_us (item_s1.echo_width_us),
		.echo_timeout  (item_s1.echo_timeout),
		.distance      (echo_dist)
	);

	upt_ctrl #(
		.SWEEP_SPAN     (SWEEP_SPAN),
		.DIST_FRAC_BITS (DIST_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.echo_dist (echo_dist),
		.cfg       (cfg_regs),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind          <= item.kind;
			item_s1.mode          <= item.mode;
			item_s1.echo_width_us <= item.echo_width_us;
			item_s1.echo_timeout  <= item.echo_timeout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid         = valid_s2;
	assign result.distance      = res_s2.distance;
	assign result.status        = res_s2.status;
	assign result.servo_angle   = res_s2.servo_angle;
	assign result.servo_move    = res_s2.servo_move;
	assign result.found_angle   = res_s2.found_angle;
	assign result.pole_distance = res_s2.pole_distance;

endmodule

FILE: rtl/core/upt_cfg_regs.sv
module upt_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [upt_pkg::IDXW-1:0] wr_index,
	input  logic [upt_pkg::DW-1:0]   wr_data,
	output upt_pkg::cfg_t            cfg
);

	upt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_ceiling     <= 16'd6400;
			cfg_q.wait_tolerance   <= 16'd640;
			cfg_q.wait_window      <= 6'd50;
			cfg_q.drive_tolerance  <= 16'd320;
			cfg_q.drive_loss_count <= 4'd3;
			cfg_q.arrive_distance  <= 16'd640;
			cfg_q.search_tolerance <= 16'd640;
			cfg_q.search_window    <= 6'd10;
		end else if (wr_en) begin
			unique case (wr_index)
				upt_pkg::REG_WAIT_CEIL:  cfg_q.wait_ceiling     <= wr_data;
				upt_pkg::REG_WAIT_TOL:   cfg_q.wait_tolerance   <= wr_data;
				upt_pkg::REG_WAIT_WIN:   cfg_q.wait_window      <= wr_data[5:0];
				upt_pkg::REG_DRIVE_TOL:  cfg_q.drive_tolerance  <= wr_data;
				upt_pkg::REG_DRIVE_LOSS: cfg_q.drive_loss_count <= wr_data[3:0];
				upt_pkg::REG_ARRIVE:     cfg_q.arrive_distance  <= wr_data;
				upt_pkg::REG_SEARCH_TOL: cfg_q.search_tolerance <= wr_data;
				upt_pkg::REG_SEARCH_WIN: cfg_q.search_window    <= wr_data[5:0];
				default:                 cfg_q                  <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/upt_dist_conv.sv
module upt_dist_conv #(
	parameter int DIST_FRAC_BITS = upt_pkg::DEF_DIST_FRAC_BITS
) (
	input  logic [upt_pkg::DW-1:0] echo_width_us,
	input  logic                   echo_timeout,
	output logic [upt_pkg::DW-1:0] distance
);

	localparam int XW = upt_pkg::DW + DIST_FRAC_BITS;
	localparam int SH = XW + 6;
	localparam int MW = SH - 5;
	localparam int QW = XW - 5;
	localparam int PW = XW + MW;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'd57) / 64'd58);
	localparam logic [QW-1:0] SAT = QW'(999 << DIST_FRAC_BITS);

	logic [XW-1:0] scaled;
	logic [PW-1:0] prod;
	logic [QW-1:0] quot;

	// exact floor(x / 58) for x below 2^XW by reciprocal multiply
	assign scaled = XW'(echo_width_us) << DIST_FRAC_BITS;
	assign prod   = PW'(scaled) * PW'(RECIP);
	assign quot   = prod[PW-1:SH];

	always_comb begin
		if (echo_timeout || echo_width_us == '0 || quot > SAT) begin
			distance = upt_pkg::DW'(SAT);
		end else begin
			distance = upt_pkg::DW'(quot);
		end
	end

endmodule

FILE: rtl/core/upt_ctrl.sv
module upt_ctrl #(
	parameter int SWEEP_SPAN     = upt_pkg::DEF_SWEEP_SPAN,
	parameter int DIST_FRAC_BITS = upt_pkg::DEF_DIST_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  upt_pkg::item_t         item,
	input  logic [upt_pkg::DW-1:0] echo_dist,
	input  upt_pkg::cfg_t          cfg,
	output upt_pkg::result_t       res
);

	localparam logic [upt_pkg::AW-1:0] CENTER = upt_pkg::AW'(90);
	localparam logic [upt_pkg::AW-1:0] LOW    = upt_pkg::AW'(90 - SWEEP_SPAN);
	localparam logic [upt_pkg::AW-1:0] HIGH   = upt_pkg::AW'(90 + SWEEP_SPAN);
	localparam logic [upt_pkg::DW-1:0] SAT_RESET = upt_pkg::DW'(999 << DIST_FRAC_BITS);

	typedef struct packed {
		logic [upt_pkg::DW-1:0] prev;
		logic [upt_pkg::DW-1:0] pole;
		logic [5:0]             run;
		logic [upt_pkg::AW-1:0] angle;
		logic                   up;
		logic [7:0]             readings;
		logic [1:0]             mode;
		logic                   busy;
	} state_t;

	state_t st_q;
	state_t nxt;

	function automatic logic [upt_pkg::DW-1:0] absdiff(
		input logic [upt_pkg::DW-1:0] a,
		input logic [upt_pkg::DW-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

	logic [upt_pkg::DW-1:0] diff_prev;
	logic [upt_pkg::DW-1:0] diff_pole;
	logic [5:0]             run_inc;
	logic                   done;

	assign diff_prev = absdiff(echo_dist, st_q.prev);
	assign diff_pole = absdiff(echo_dist, st_q.pole);
	assign run_inc   = (st_q.run == 6'd63) ? st_q.run : st_q.run + 6'd1;

	always_comb begin
		nxt             = st_q;
		done            = 1'b0;
		res.distance    = '0;
		res.status      = upt_pkg::ST_RUN;
		res.servo_angle = '0;
		res.servo_move  = 1'b0;
		res.found_angle = '0;
		if (item.kind) begin
			if (item.mode == upt_pkg::MODE_RSVD) begin
				res.status = st_q.busy ? upt_pkg::ST_RUN : upt_pkg::ST_IDLE;
			end else begin
				nxt.mode = item.mode;
				nxt.run  = '0;
				nxt.busy = 1'b1;
				if (item.mode == upt_pkg::MODE_DRIVE && st_q.pole <= cfg.arrive_distance) begin
					nxt.busy   = 1'b0;
					res.status = upt_pkg::ST_OK;
				end else if (item.mode == upt_pkg::MODE_SEARCH) begin
					nxt.angle    = CENTER;
					nxt.up       = 1'b0;
					nxt.readings = '0;
				end
			end
		end else begin
			res.distance = echo_dist;
			if (!st_q.busy) begin
				res.status = upt_pkg::ST_IDLE;
			end else begin
				unique case (st_q.mode)
					upt_pkg::MODE_WAIT: begin
						if (echo_dist < cfg.wait_ceiling) begin
							nxt.run = (diff_prev < cfg.wait_tolerance) ? run_inc : '0;
							if (nxt.run >= cfg.wait_window) begin
								nxt.pole   = echo_dist;
								nxt.busy   = 1'b0;
								res.status = upt_pkg::ST_OK;
							end
						end
						nxt.prev = echo_dist;
					end
					upt_pkg::MODE_DRIVE: begin
						if (diff_pole > cfg.drive_tolerance) begin
							nxt.run = run_inc;
						end else begin
							nxt.run  = '0;
							nxt.pole = echo_dist;
							nxt.prev = echo_dist;
						end
						if (nxt.run >= 6'(cfg.drive_loss_count)) begin
							nxt.busy   = 1'b0;
							res.status = upt_pkg::ST_FAIL;
						end else if (echo_dist <= cfg.arrive_distance) begin
							nxt.busy   = 1'b0;
							res.status = upt_pkg::ST_OK;
						end
					end
					default: begin
						res.servo_move = 1'b1;
						nxt.run = (diff_pole < cfg.search_tolerance) ? run_inc : '0;
						done    = nxt.run >= cfg.search_window;
						if (!st_q.up) begin
							if (st_q.angle <= LOW) begin
								nxt.up       = 1'b1;
								nxt.angle    = CENTER;
								nxt.readings = '0;
							end else begin
								nxt.angle = st_q.angle - 8'd1;
							end
						end else begin
							if (st_q.angle >= HIGH) begin
								nxt.busy        = 1'b0;
								nxt.angle       = CENTER;
								res.status      = upt_pkg::ST_FAIL;
								res.servo_angle = CENTER;
							end else begin
								nxt.angle = st_q.angle + 8'd1;
							end
						end
						if (nxt.busy) begin
							if (nxt.readings != 8'd255) begin
								nxt.readings = nxt.readings + 8'd1;
							end
							res.servo_angle = nxt.angle;
							if (done) begin
								nxt.prev        = echo_dist;
								nxt.busy        = 1'b0;
								res.status      = upt_pkg::ST_OK;
								res.found_angle = (nxt.readings == 8'(cfg.search_window)) ?
									CENTER : nxt.angle;
								res.servo_angle = CENTER;
							end
						end
					end
				endcase
			end
		end
		res.pole_distance = nxt.pole;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prev     <= SAT_RESET;
			st_q.pole     <= '0;
			st_q.run      <= '0;
			st_q.angle    <= CENTER;
			st_q.up       <= 1'b0;
			st_q.readings <= '0;
			st_q.mode     <= upt_pkg::MODE_WAIT;
			st_q.busy     <= 1'b0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

endmodule

FILE: rtl/core/upt_checker.sv
module upt_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [upt_pkg::DW-1:0] res_distance,
	input logic [1:0]             res_status,
	input logic [upt_pkg::AW-1:0] res_servo_angle,
	input logic                   res_servo_move,
	input logic [upt_pkg::AW-1:0] res_found_angle,
	input logic [upt_pkg::DW-1:0] res_pole_distance
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_distance) &&
		$stable(res_status) && $stable(res_servo_angle) && $stable(res_servo_move) &&
		$stable(res_found_angle) && $stable(res_pole_distance))
		else $error("result item changed while stalled");

	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_servo_move |-> res_servo_angle == '0 && res_found_angle == '0)
		else $error("servo command without move");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found_angle != '0 |-> res_status == upt_pkg::ST_OK &&
		res_servo_move && res_servo_angle == upt_pkg::AW'(90))
		else $error("found angle outside search success");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == upt_pkg::ST_IDLE |-> !res_servo_move)
		else $error("servo move while idle");

endmodule

bind ultrasonic_pole_tracker_unit upt_checker u_upt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.res_distance      (result.distance),
	.res_status        (result.status),
	.res_servo_angle   (result.servo_angle),
	.res_servo_move    (result.servo_move),
	.res_found_angle   (result.found_angle),
	.res_pole_distance (result.pole_distance)
);
